>>> design/pfb_pkg.sv
// Package for the page framebuffer blit block: frame geometry, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package pfb_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int NUM_PAGES    = FRAME_HEIGHT / PAGE_ROWS;
  localparam int STORE_DEPTH  = FRAME_WIDTH * NUM_PAGES;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int BIT_W  = $clog2(PAGE_ROWS);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_DROP   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RMW,
    ST_FLUSH,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic apply_begin;
    logic drop;
    logic rmw_rd;
    logic cursor_adv;
    logic rd_page;
    logic take_page;
  } pfb_cmd_t;

  typedef struct packed {
    logic  clr_last;
    mode_t mode;
    logic  data_ok;
    logic  pix_last;
  } pfb_stat_t;

endpackage

>>> design/pfb_ctrl.sv
// Controller state machine of the page framebuffer blit block.
// Depends on pfb_pkg; drives pfb_datapath through pfb_cmd_t.
`timescale 1ns / 1ps
module pfb_ctrl import pfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  input  pfb_stat_t stat,
  output pfb_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_BEGIN: state_next = ST_RESP;
          MODE_DATA:  state_next = stat.data_ok ? ST_RMW : ST_RESP;
          MODE_READ:  state_next = ST_READ;
          MODE_NONE:  state_next = ST_RESP;
          default:    state_next = ST_RESP;
        endcase
      end
      ST_RMW: begin
        if (stat.pix_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: state_next = ST_RESP;
      ST_READ:  state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_BEGIN: cmd.apply_begin = 1'b1;
          MODE_DATA: begin
            cmd.drop = !stat.data_ok;
          end
          MODE_READ: cmd.rd_page = 1'b1;
          MODE_NONE: cmd = '0;
          default:   cmd = '0;
        endcase
      end
      ST_RMW:   cmd.rmw_rd = 1'b1;
      ST_FLUSH: cmd.cursor_adv = 1'b1;
      ST_READ:  cmd.take_page = 1'b1;
      ST_RESP:  done = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> design/pfb_datapath.sv
// Datapath of the page framebuffer blit block: page store, blit registers,
// cursor and read-modify-write pipeline. Depends on pfb_pkg.
`timescale 1ns / 1ps
module pfb_datapath import pfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pfb_cmd_t   cmd,
  output pfb_stat_t  stat,
  input  logic [1:0] mode,
  input  logic [6:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [7:0] bm_width,
  input  logic [6:0] bm_height,
  input  logic [7:0] data_byte,
  input  logic [2:0] page_sel,
  input  logic [6:0] column_sel,
  output logic [1:0] status,
  output logic [7:0] page_byte
);

  // latched item
  logic [1:0] mode_q;
  logic [6:0] pos_x_q;
  logic [5:0] pos_y_q;
  logic [7:0] bm_width_q;
  logic [6:0] bm_height_q;
  logic [7:0] data_byte_q;
  logic [2:0] page_sel_q;
  logic [6:0] column_sel_q;

  // blit state
  logic [6:0] origin_x;
  logic [5:0] origin_y;
  logic [7:0] blit_width;
  logic [6:0] blit_height;
  logic [6:0] cursor_row;
  logic [7:0] cursor_col;
  logic       blit_rejected;

  logic [ADDR_W-1:0] clr_cnt;
  logic [BIT_W-1:0]  pix_cnt;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [BIT_W-1:0]  wr_bitpos_q;
  logic              wr_bit_q;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rd_data;

  logic [7:0] sum_y;
  logic [8:0] sum_x;
  logic       reject;
  logic [6:0] row_sum;
  logic [7:0] col_sum;
  logic [ROW_W-1:0] row_abs;
  logic [COL_W-1:0] col_abs;
  logic [ADDR_W-1:0] pix_addr;
  logic [8:0] col_step;
  logic [7:0] bit_mask;
  logic [7:0] merged;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        wr_data;

  // begin bounds test, last row and column excluded
  assign sum_y  = {2'b0, pos_y_q} + {1'b0, bm_height_q};
  assign sum_x  = {2'b0, pos_x_q} + {1'b0, bm_width_q};
  assign reject = (sum_y >= 8'(FRAME_HEIGHT)) || (sum_x >= 9'(FRAME_WIDTH)) ||
                  (bm_width_q == 8'd0) || (bm_width_q[2:0] != 3'd0);

  // an open blit keeps every pixel inside the frame
  assign row_sum  = {1'b0, origin_y} + cursor_row;
  assign col_sum  = {1'b0, origin_x} + cursor_col + {5'b0, pix_cnt};
  assign row_abs  = row_sum[ROW_W-1:0];
  assign col_abs  = col_sum[COL_W-1:0];
  assign pix_addr = {row_abs[ROW_W-1:BIT_W], col_abs};
  assign col_step = {1'b0, cursor_col} + 9'd8;

  assign bit_mask = 8'd1 << wr_bitpos_q;
  assign merged   = wr_bit_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  assign mem_we  = cmd.clr_step | wr_pend;
  assign wr_addr = cmd.clr_step ? clr_cnt : wr_addr_q;
  assign wr_data = cmd.clr_step ? 8'd0 : merged;
  assign mem_re  = cmd.rmw_rd | cmd.rd_page;
  assign rd_addr = cmd.rd_page ? {page_sel_q, column_sel_q} : pix_addr;

  always_ff @(posedge clk) begin
    if (mem_we) store[wr_addr] <= wr_data;
    if (mem_re) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q       <= mode;
      pos_x_q      <= pos_x;
      pos_y_q      <= pos_y;
      bm_width_q   <= bm_width;
      bm_height_q  <= bm_height;
      data_byte_q  <= data_byte;
      page_sel_q   <= page_sel;
      column_sel_q <= column_sel;
    end
    if (cmd.rmw_rd) begin
      wr_addr_q   <= pix_addr;
      wr_bitpos_q <= row_abs[BIT_W-1:0];
      wr_bit_q    <= data_byte_q[pix_cnt];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      status    <= STAT_DONE;
      page_byte <= 8'd0;
    end else if (cmd.apply_begin && reject) begin
      status <= STAT_REJECT;
    end else if (cmd.drop) begin
      status <= STAT_DROP;
    end else if (cmd.take_page) begin
      page_byte <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      blit_width    <= '0;
      blit_height   <= '0;
      cursor_row    <= '0;
      cursor_col    <= '0;
      blit_rejected <= 1'b1;
      clr_cnt       <= '0;
      pix_cnt       <= '0;
      wr_pend       <= 1'b0;
    end else begin
      wr_pend <= cmd.rmw_rd;
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.rmw_rd) pix_cnt <= pix_cnt + 1'b1;
      if (cmd.apply_begin) begin
        if (reject) begin
          blit_rejected <= 1'b1;
        end else begin
          blit_rejected <= 1'b0;
          origin_x      <= pos_x_q;
          origin_y      <= pos_y_q;
          blit_width    <= bm_width_q;
          blit_height   <= bm_height_q;
          cursor_row    <= '0;
          cursor_col    <= '0;
        end
      end
      if (cmd.cursor_adv) begin
        if (col_step >= {1'b0, blit_width}) begin
          cursor_col <= '0;
          cursor_row <= cursor_row + 7'd1;
        end else begin
          cursor_col <= col_step[7:0];
        end
      end
    end
  end

  assign stat.clr_last = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
  assign stat.mode     = mode_t'(mode_q);
  assign stat.data_ok  = !blit_rejected && (cursor_row < blit_height) &&
                         (blit_width != 8'd0);
  assign stat.pix_last = (pix_cnt == BIT_W'(PAGE_ROWS - 1));

endmodule

>>> design/page_framebuffer_blit.sv
// Top level of the page framebuffer blit block: controller plus datapath.
// Depends on pfb_pkg, pfb_ctrl and pfb_datapath.
`timescale 1ns / 1ps
// Monochrome 128x64 frame store kept as vertical page bytes.
// Command channel: an item is taken at a rising edge with start high and busy
// low; mode selects begin blit, bitmap data byte or page read. Each item gives
// one result on status/page_byte, marked by done for exactly one cycle; the
// receiver takes it then and cannot hold it off.
// Begin, unused mode and a dropped data byte go from dispatch to the result
// state; a page read passes a read state on the way. busy drops the cycle
// after done. A written data byte is eight read-modify-write passes through
// the single-port-write page store, one column byte a cycle, then a flush
// state drains the last write.
// Reset: rst clears the blit state and then sweeps zeros through all 1024
// store entries, one per cycle; busy stays high until the sweep is done.
module page_framebuffer_blit import pfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [6:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [7:0] bm_width,
  input  logic [6:0] bm_height,
  input  logic [7:0] data_byte,
  input  logic [2:0] page_sel,
  input  logic [6:0] column_sel,
  output logic       done,
  output logic [1:0] status,
  output logic [7:0] page_byte
);

  pfb_cmd_t  cmd;
  pfb_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  pfb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .bm_width   (bm_width),
    .bm_height  (bm_height),
    .data_byte  (data_byte),
    .page_sel   (page_sel),
    .column_sel (column_sel),
    .status     (status),
    .page_byte  (page_byte)
  );

endmodule

>>> design/pfb_checker.sv
// Port-level checks for page_framebuffer_blit, attached by bind.
// Depends on pfb_pkg for the status codes.
`timescale 1ns / 1ps
module pfb_checker import pfb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [7:0] page_byte
);

  // an accepted beat makes the block busy right after it
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block idle right after accepting a beat");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while accepting new beats");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_DONE || status == STAT_REJECT || status == STAT_DROP))
    else $error("undefined status code");

  // only a successful item may carry page data
  a_err_no_byte: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_DONE |-> page_byte == 8'd0)
    else $error("page byte nonzero on error result");

endmodule

bind page_framebuffer_blit pfb_checker u_pfb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .page_byte (page_byte)
);

>>> verif/page_framebuffer_blit_checker.sv
// Checker for page_framebuffer_blit: watches the command and result ports, keeps
// its own copy of the frame and the open blit, and scores every result beat.
// Depends on pfb_pkg.
`timescale 1ns / 1ps
module page_framebuffer_blit_checker import pfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] mode,
  input  logic [6:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [7:0] bm_width,
  input  logic [6:0] bm_height,
  input  logic [7:0] data_byte,
  input  logic [2:0] page_sel,
  input  logic [6:0] column_sel,
  input  logic       done,
  input  logic [1:0] status,
  input  logic [7:0] page_byte,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    status_t    status;
    logic [7:0] page_byte;
  } frame_reply_t;

  logic [7:0]   frame_model [STORE_DEPTH];
  int unsigned  org_x, org_y, blit_w, blit_h, cur_row, cur_col;
  bit           blit_closed;
  frame_reply_t expected_replies [$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // Apply one command beat to the frame copy and return the reply it must give.
  task automatic step_frame(input mode_t m, input logic [6:0] x, input logic [5:0] y,
                            input logic [7:0] w, input logic [6:0] h,
                            input logic [7:0] d, input logic [2:0] pg,
                            input logic [6:0] col, output frame_reply_t reply);
    int unsigned row, pix_col, idx;
    reply.status    = STAT_DONE;
    reply.page_byte = '0;
    case (m)
      MODE_BEGIN: begin
        // the bounds test is >=, so the last row and column stay out of reach
        if (int'(y) + int'(h) >= FRAME_HEIGHT || int'(x) + int'(w) >= FRAME_WIDTH ||
            w == 8'd0 || w[2:0] != 3'd0) begin
          blit_closed  = 1'b1;
          reply.status = STAT_REJECT;
        end else begin
          blit_closed = 1'b0;
          org_x   = 32'(x);
          org_y   = 32'(y);
          blit_w  = 32'(w);
          blit_h  = 32'(h);
          cur_row = 0;
          cur_col = 0;
        end
      end
      MODE_DATA: begin
        if (blit_closed || cur_row >= blit_h || blit_w == 0) begin
          reply.status = STAT_DROP;
        end else begin
          row = org_y + cur_row;
          for (int i = 0; i < 8; i++) begin
            pix_col = org_x + cur_col + i;
            if (row < FRAME_HEIGHT && pix_col < FRAME_WIDTH) begin
              idx = (row / PAGE_ROWS) * FRAME_WIDTH + pix_col;
              frame_model[idx][row % PAGE_ROWS] = d[i];
            end
          end
          cur_col += 8;
          if (cur_col >= blit_w) begin
            cur_col = 0;
            cur_row++;
          end
        end
      end
      MODE_READ: begin
        if (pg < NUM_PAGES && col < FRAME_WIDTH)
          reply.page_byte = frame_model[pg * FRAME_WIDTH + col];
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    frame_reply_t want;
    if (rst) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      org_x = 0; org_y = 0; blit_w = 0; blit_h = 0; cur_row = 0; cur_col = 0;
      blit_closed = 1'b1;
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: status %0d byte 0x%02h",
                                    status, page_byte));
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (page_byte !== want.page_byte)
            report_mismatch($sformatf("page_byte 0x%02h, expected 0x%02h",
                                      page_byte, want.page_byte));
        end
      end
      if (start && !busy) begin
        step_frame(mode_t'(mode), pos_x, pos_y, bm_width, bm_height, data_byte,
                   page_sel, column_sel, want);
        expected_replies.push_back(want);
      end
    end
    pending <= expected_replies.size();
  end

endmodule

>>> verif/page_framebuffer_blit_tb.sv
// Testbench top for page_framebuffer_blit: clock, reset, directed and random
// command beats, and the verdict. Depends on pfb_pkg, the block and its checker.
`timescale 1ns / 1ps
module page_framebuffer_blit_tb import pfb_pkg::*;;

  logic       clk;
  logic       rst        = 1'b1;
  logic       start      = 1'b0;
  logic [1:0] mode       = MODE_NONE;
  logic [6:0] pos_x      = '0;
  logic [5:0] pos_y      = '0;
  logic [7:0] bm_width   = '0;
  logic [6:0] bm_height  = '0;
  logic [7:0] data_byte  = '0;
  logic [2:0] page_sel   = '0;
  logic [6:0] column_sel = '0;
  logic       busy, done;
  logic [1:0] status;
  logic [7:0] page_byte;
  int         fail_count, pending;
  int         beats_sent = 0;
  int         gap_limit  = 8;

  page_framebuffer_blit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .pos_x(pos_x), .pos_y(pos_y), .bm_width(bm_width), .bm_height(bm_height),
    .data_byte(data_byte), .page_sel(page_sel), .column_sel(column_sel),
    .done(done), .status(status), .page_byte(page_byte)
  );

  page_framebuffer_blit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .pos_x(pos_x), .pos_y(pos_y), .bm_width(bm_width), .bm_height(bm_height),
    .data_byte(data_byte), .page_sel(page_sel), .column_sel(column_sel),
    .done(done), .status(status), .page_byte(page_byte),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Drive one command beat after a random gap and hold it until accepted.
  task automatic issue(input mode_t m, input logic [6:0] x, input logic [5:0] y,
                       input logic [7:0] w, input logic [6:0] h, input logic [7:0] d,
                       input logic [2:0] pg, input logic [6:0] col);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode       <= m;
    pos_x      <= x;
    pos_y      <= y;
    bm_width   <= w;
    bm_height  <= h;
    data_byte  <= d;
    page_sel   <= pg;
    column_sel <= col;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (m != MODE_NONE) beats_sent++;
  endtask

  task automatic begin_blit(input int x, input int y, input int w, input int h);
    issue(MODE_BEGIN, 7'(x), 6'(y), 8'(w), 7'(h), 8'($urandom), 3'($urandom),
          7'($urandom));
  endtask

  task automatic send_pixels(input logic [7:0] d);
    issue(MODE_DATA, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom), d,
          3'($urandom), 7'($urandom));
  endtask

  task automatic read_page(input int pg, input int col);
    issue(MODE_READ, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
          8'($urandom), 3'(pg), 7'(col));
  endtask

  task automatic send_unused();
    issue(MODE_NONE, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
          8'($urandom), 3'($urandom), 7'($urandom));
  endtask

  // Hold off until every outstanding result beat has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int w, h, x, y, n, sel, row_off;
    logic [7:0] d;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: drops, reads of a blank frame, bounds edges, odd widths
    send_pixels(8'hA5);
    read_page(0, 0);
    send_unused();
    begin_blit(0, 0, 8, 1);
    send_pixels(8'hFF);
    send_pixels(8'h55);
    read_page(0, 0);
    read_page(0, 7);
    begin_blit(0, 0, 0, 4);
    begin_blit(0, 0, 12, 4);
    send_pixels(8'h0F);
    begin_blit(119, 0, 8, 1);
    send_pixels(8'h81);
    read_page(0, 126);
    begin_blit(120, 0, 8, 1);
    begin_blit(0, 63, 8, 1);
    begin_blit(0, 62, 8, 1);
    send_pixels(8'hFF);
    read_page(7, 3);
    begin_blit(10, 5, 16, 0);
    send_pixels(8'hFF);
    begin_blit(127, 63, 255, 127);
    begin_blit(0, 0, 8, 1);
    send_pixels(8'h00);
    read_page(0, 0);
    wait_drained();

    while (beats_sent < 1050) begin
      gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 8;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // well-formed blit, mostly small; now and then wide or tall
        w = 8 * $urandom_range(1, 4);
        h = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) w = 8 * $urandom_range(1, 15);
        else if ($urandom_range(0, 9) == 0) begin
          w = 8;
          h = $urandom_range(1, 63);
        end
        x = $urandom_range(0, 127 - w);
        y = $urandom_range(0, 63 - h);
        n = (w / 8) * h;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
        else if ($urandom_range(0, 7) == 0) n = n + $urandom_range(1, 3);
        begin_blit(x, y, w, h);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = 8'($urandom);
          endcase
          send_pixels(d);
        end
        repeat ($urandom_range(1, 4)) begin
          row_off = $urandom_range(0, h - 1);
          read_page((y + row_off) / PAGE_ROWS, x + $urandom_range(0, w - 1));
        end
      end else if (sel < 80) begin
        read_page($urandom_range(0, 7), $urandom_range(0, 127));
      end else if (sel < 90) begin
        issue(MODE_BEGIN, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
              8'($urandom), 3'($urandom), 7'($urandom));
      end else if (sel < 95) begin
        send_pixels(8'($urandom));
      end else begin
        send_unused();
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/pfb_pkg.sv
design/pfb_ctrl.sv
design/pfb_datapath.sv
design/page_framebuffer_blit.sv
design/pfb_checker.sv
verif/page_framebuffer_blit_checker.sv
verif/page_framebuffer_blit_tb.sv
